>>> src/adaptive_arithmetic_encoder_top_assert.svh
// Assertion macros for the encoder's checker file.
`ifndef ADAPTIVE_ARITHMETIC_ENCODER_TOP_ASSERT_SVH
`define ADAPTIVE_ARITHMETIC_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication under reset.
`define AAE_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("encoder check failed");

// Next-cycle implication under reset.
`define AAE_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("encoder check failed");

`endif

>>> src/aae_pkg.sv
// Types and constants of the adaptive arithmetic encoder.
`default_nettype none
package aae_pkg;

    localparam int CNT_W       = 15;
    localparam int FOLLOW_W    = 32;
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = 5;

    localparam logic [CNT_W-1:0] LIMIT_MAX = 15'd16384;

    typedef enum logic [1:0] {
        KIND_ENCODE = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_START  = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CUM_RD,
        ST_CUM_ACC,
        ST_LO_GO,
        ST_LO_WAIT,
        ST_RG_GO,
        ST_RG_WAIT,
        ST_UPD,
        ST_RESC_RD,
        ST_RESC_WR,
        ST_RENORM,
        ST_FIN0,
        ST_FIN1,
        ST_FIN2,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] symbol;
    } t_in_word;

    typedef struct packed {
        logic                lead_bit;
        logic [FOLLOW_W-1:0] follow_count;
        logic                last;
    } t_out_word;

endpackage
`default_nettype wire

>>> src/aae_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module aae_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> src/aae_divider.sv
// Shared multiply-then-divide unit: one product, then one quotient bit per cycle.
`default_nettype none
module aae_divider #(
    parameter int A_W = 16,
    parameter int B_W = 15
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [A_W-1:0] i_a,
    input  wire logic [B_W-1:0] i_b,
    input  wire logic [B_W-1:0] i_div,
    output logic                o_done,
    output logic      [A_W-1:0] o_quot
);

    localparam int P_W = A_W + B_W;
    localparam int C_W = $clog2(P_W + 1);

    logic [P_W-1:0] r_dvd;
    logic [B_W-1:0] r_rem;
    logic [B_W-1:0] r_div;
    logic [C_W-1:0] r_cnt;
    logic           r_done;
    logic [B_W:0]   trial;
    logic [B_W:0]   diff;
    logic           ge;

    // restoring step
    assign trial = {r_rem, r_dvd[P_W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= C_W'(P_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - C_W'(1);
                if (r_cnt == C_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: product loads the shifter, quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= P_W'(i_a) * P_W'(i_b);
            r_rem <= '0;
            r_div <= i_div;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[B_W-1:0] : trial[B_W-1:0];
            r_dvd <= {r_dvd[P_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd[A_W-1:0];

endmodule
`default_nettype wire

>>> src/adaptive_arithmetic_encoder_top.sv
// Adaptive multi-symbol arithmetic encoder, top level.
// Usage:
//  - Input channel (i_in_valid/o_in_ready, i_in_data) takes one command word:
//    encode symbol, finish stream, start coder or reset context counts.
//  - Output channel (o_out_valid/i_out_ready, o_out_data) gives code bits with
//    their follow counts; last marks the final word of a command.
//  - Config channel (i_cfg_valid/o_cfg_ready, i_cfg_data) writes the rescale
//    limit; always ready, values above 16384 are clamped.
// Flow: one command at a time. An encode sweeps the count RAM up to the symbol to
//    form its cumulative count, runs two divisions on the serial divider (one
//    quotient bit a cycle), updates the count, halves all counts when the total
//    would pass the limit, then renormalizes (up to REG_BITS-2 steps, paused
//    while the output is stalled). Finish goes through FIN0, FIN1, FIN2 and FLUSH;
//    start leaves the coder idle.
// Reset: a clearing pass writes all ALPHABET counts to 1; input is
//    not ready meanwhile. A reset-context command repeats that pass.
// Stall: an output register and one holding word buffer results; a stalled
//    receiver pauses the renormalization loop and the finish steps.
`default_nettype none
module adaptive_arithmetic_encoder_top
    import aae_pkg::*;
#(
    parameter int REG_BITS = 16,
    parameter int ALPHABET = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_word         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_word             o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_data
);

    localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int IW = $clog2(ALPHABET + 1);
    localparam logic [REG_BITS-1:0] HALF    = {1'b1, {(REG_BITS-1){1'b0}}};
    localparam logic [REG_BITS-1:0] QUARTER = {2'b01, {(REG_BITS-2){1'b0}}};
    localparam logic [REG_BITS-1:0] RANGE0  = HALF - REG_BITS'(2);

    t_state              r_state, n_state;
    logic [REG_BITS-1:0] r_low, n_low;
    logic [REG_BITS-1:0] r_range, n_range;
    logic [FOLLOW_W-1:0] r_pend, n_pend;
    logic [CNT_W-1:0]    r_total, n_total;
    logic [CNT_W-1:0]    r_limit;
    logic [IW-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]    r_cum, n_cum;
    logic [CNT_W-1:0]    r_cnt_sym, n_cnt_sym;
    logic [CNT_W-1:0]    r_tsum, n_tsum;
    logic [3:0]          r_sym, n_sym;
    logic                r_hold_v, n_hold_v;
    t_out_word           r_hold, n_hold;
    logic                r_out_v, n_out_v;
    t_out_word           r_out, n_out;
    logic [RES_W-1:0]    r_nres, n_nres;

    logic             in_acc;
    logic             sym_ok;
    logic             can_emit;
    logic             e_req;
    logic             e_bit;
    logic [FOLLOW_W-1:0] e_follow;
    logic [CNT_W-1:0] tot_inc;
    logic [CNT_W-1:0] half_cnt;
    logic             idx_end;
    logic             renorm_done;
    logic             div_start;
    logic             div_done;
    logic [REG_BITS-1:0] div_quot;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [CNT_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [CNT_W-1:0] ram_rdata;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    assign in_acc      = i_in_valid && o_in_ready;
    assign sym_ok      = 32'(i_in_data.symbol) < ALPHABET;
    assign can_emit    = !r_hold_v || !r_out_v;
    assign tot_inc     = r_total + CNT_W'(1);
    assign idx_end     = (r_idx == IW'(ALPHABET - 1));
    assign renorm_done = (r_range[REG_BITS-1:REG_BITS-2] != 2'b00);
    assign half_cnt    = (ram_rdata[CNT_W-1:1] == '0) ? CNT_W'(1)
                                                      : {1'b0, ram_rdata[CNT_W-1:1]};

    // count memory
    aae_ram #(
        .WIDTH (CNT_W),
        .DEPTH (ALPHABET)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared multiply/divide unit
    assign div_start = (r_state == ST_LO_GO) || (r_state == ST_RG_GO);

    aae_divider #(
        .A_W (REG_BITS),
        .B_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (r_range),
        .i_b     ((r_state == ST_LO_GO) ? r_cum : r_cnt_sym),
        .i_div   (r_total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // emit request per state
    always_comb begin
        e_req    = 1'b0;
        e_bit    = 1'b0;
        e_follow = r_pend;
        case (r_state)
            ST_RENORM: begin
                e_req = !renorm_done &&
                        (r_low[REG_BITS-1] || (r_low[REG_BITS-1:REG_BITS-2] == 2'b00));
                e_bit = r_low[REG_BITS-1];
            end
            ST_FIN0: begin
                e_req = 1'b1;
                e_bit = r_low[REG_BITS-1];
            end
            ST_FIN1: begin
                e_req    = 1'b1;
                e_bit    = r_low[REG_BITS-2];
                e_follow = '0;
            end
            ST_FIN2: begin
                e_req    = 1'b1;
                e_bit    = 1'b1;
                e_follow = '0;
            end
            default: begin
                e_req = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:   if (idx_end) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_kind'(i_in_data.kind))
                        KIND_ENCODE: if (sym_ok) n_state = ST_CUM_RD;
                        KIND_FINISH: n_state = ST_FIN0;
                        KIND_CLEAR:  n_state = ST_CLEAR;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CUM_RD:  n_state = ST_CUM_ACC;
            ST_CUM_ACC: n_state = (r_idx == IW'(r_sym)) ? ST_LO_GO : ST_CUM_RD;
            ST_LO_GO:   n_state = ST_LO_WAIT;
            ST_LO_WAIT: if (div_done) n_state = ST_RG_GO;
            ST_RG_GO:   n_state = ST_RG_WAIT;
            ST_RG_WAIT: if (div_done) n_state = ST_UPD;
            ST_UPD:     n_state = (tot_inc > r_limit) ? ST_RESC_RD : ST_RENORM;
            ST_RESC_RD: n_state = ST_RESC_WR;
            ST_RESC_WR: n_state = idx_end ? ST_RENORM : ST_RESC_RD;
            ST_RENORM: begin
                if (renorm_done) n_state = ST_FLUSH;
            end
            ST_FIN0:    if (can_emit) n_state = ST_FIN1;
            ST_FIN1:    if (can_emit) n_state = ST_FIN2;
            ST_FIN2:    if (can_emit) n_state = ST_FLUSH;
            ST_FLUSH:   if (!r_hold_v || !r_out_v) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_low     = r_low;
        n_range   = r_range;
        n_pend    = r_pend;
        n_total   = r_total;
        n_idx     = r_idx;
        n_cum     = r_cum;
        n_cnt_sym = r_cnt_sym;
        n_tsum    = r_tsum;
        n_sym     = r_sym;
        n_hold_v  = r_hold_v;
        n_hold    = r_hold;
        n_out_v   = r_out_v && !i_out_ready;
        n_out     = r_out;
        n_nres    = r_nres;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = CNT_W'(1);
        ram_raddr = r_idx[AW-1:0];

        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_idx  = r_idx + IW'(1);
                if (idx_end) begin
                    n_total = CNT_W'(ALPHABET);
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx  = '0;
                    n_cum  = '0;
                    n_nres = '0;
                    n_sym  = i_in_data.symbol;
                    if (t_kind'(i_in_data.kind) == KIND_START) begin
                        n_low   = '0;
                        n_range = RANGE0;
                        n_pend  = '0;
                    end
                end
            end
            ST_CUM_ACC: begin
                if (r_idx == IW'(r_sym)) begin
                    n_cnt_sym = ram_rdata;
                end else begin
                    n_cum = r_cum + ram_rdata;
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_LO_WAIT: begin
                if (div_done) n_low = r_low + div_quot;
            end
            ST_RG_WAIT: begin
                if (div_done) n_range = (div_quot == '0) ? REG_BITS'(1) : div_quot;
            end
            ST_UPD: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_sym);
                ram_wdata = r_cnt_sym + CNT_W'(1);
                n_total   = tot_inc;
                n_idx     = '0;
                n_tsum    = '0;
            end
            ST_RESC_WR: begin
                ram_we    = 1'b1;
                ram_wdata = half_cnt;
                n_tsum    = r_tsum + half_cnt;
                n_idx     = r_idx + IW'(1);
                if (idx_end) n_total = r_tsum + half_cnt;
            end
            ST_RENORM: begin
                if (!renorm_done && (!e_req || can_emit)) begin
                    if (r_low[REG_BITS-1]) begin
                        n_low = {1'b0, r_low[REG_BITS-2:0]} << 1;
                    end else if (r_low[REG_BITS-2]) begin
                        n_low  = {2'b00, r_low[REG_BITS-3:0]} << 1;
                        n_pend = (r_pend == '1) ? r_pend : r_pend + FOLLOW_W'(1);
                    end else begin
                        n_low = r_low << 1;
                    end
                    n_range = r_range << 1;
                end
            end
            ST_FLUSH: begin
                if (r_hold_v && !r_out_v) begin
                    n_out      = r_hold;
                    n_out.last = 1'b1;
                    n_out_v    = 1'b1;
                    n_hold_v   = 1'b0;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase

        // shared result emit: older held word moves to the output register
        if (e_req && can_emit) begin
            n_pend = '0;
            if (r_nres < RES_W'(MAX_RESULTS)) begin
                if (r_hold_v) begin
                    n_out   = r_hold;
                    n_out_v = 1'b1;
                end
                n_hold.lead_bit     = e_bit;
                n_hold.follow_count = e_follow;
                n_hold.last         = 1'b0;
                n_hold_v            = 1'b1;
                n_nres              = r_nres + RES_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_low    <= '0;
            r_range  <= RANGE0;
            r_pend   <= '0;
            r_total  <= CNT_W'(ALPHABET);
            r_limit  <= LIMIT_MAX;
            r_idx    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_nres   <= '0;
        end else begin
            r_state  <= n_state;
            r_low    <= n_low;
            r_range  <= n_range;
            r_pend   <= n_pend;
            r_total  <= n_total;
            r_idx    <= n_idx;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
            r_nres   <= n_nres;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= (i_cfg_data > LIMIT_MAX) ? LIMIT_MAX : i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cum     <= n_cum;
        r_cnt_sym <= n_cnt_sym;
        r_tsum    <= n_tsum;
        r_sym     <= n_sym;
        r_hold    <= n_hold;
        r_out     <= n_out;
    end

endmodule
`default_nettype wire

>>> src/aae_checker.sv
// Port-level checks for the encoder top, bound into every instance.
`default_nettype none
`include "adaptive_arithmetic_encoder_top_assert.svh"
module aae_checker
    import aae_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire t_in_word         i_in_data,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire t_out_word        o_out_data,
    input wire logic             i_cfg_valid,
    input wire logic             o_cfg_ready,
    input wire logic [CNT_W-1:0] i_cfg_data
);

    logic in_acc;
    logic cfg_seen;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_seen = i_cfg_valid && (i_cfg_data == i_cfg_data);

    // a result word is held until taken
    `AAE_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // finish keeps the coder busy while its three words go out
    `AAE_ASSERT_NEXT(a_finish_busy, in_acc && (i_in_data.kind == KIND_FINISH), !o_in_ready)

    // start leaves the coder ready in the next cycle, with no results
    `AAE_ASSERT_NEXT(a_start_quick, in_acc && (i_in_data.kind == KIND_START), o_in_ready)

    // a context reset runs the clearing pass, config stays open
    `AAE_ASSERT_NEXT(a_clear_busy, in_acc && (i_in_data.kind == KIND_CLEAR),
                     !o_in_ready && (o_cfg_ready || !cfg_seen))

endmodule

bind adaptive_arithmetic_encoder_top aae_checker u_aae_checker (.*);
`default_nettype wire
